// ===== rtl/core/scclc_pkg.sv =====
// Shared codes and widths for the smart-card contact level checker.
package scclc_pkg;

  localparam int unsigned MV_W   = 13;
  localparam int unsigned CODE_W = 3;

  typedef logic [MV_W-1:0]   mv_t;
  typedef logic [CODE_W-1:0] code_t;

  // contact mode
  localparam code_t MODE_VCC    = 3'd0;
  localparam code_t MODE_RST    = 3'd1;
  localparam code_t MODE_IO     = 3'd2;
  localparam code_t MODE_CLK    = 3'd3;
  localparam code_t MODE_VPP    = 3'd4;
  localparam code_t MODE_HIGHZ  = 3'd5;
  localparam code_t MODE_STATEA = 3'd6;

  // reported level
  localparam code_t LVL_ERR    = 3'd0;
  localparam code_t LVL_HIGH   = 3'd1;
  localparam code_t LVL_LOW    = 3'd2;
  localparam code_t LVL_HIGHZ  = 3'd3;
  localparam code_t LVL_STATEA = 3'd4;

  // supply class
  localparam code_t CLS_OFF     = 3'd0;
  localparam code_t CLS_A       = 3'd1;
  localparam code_t CLS_B       = 3'd2;
  localparam code_t CLS_C       = 3'd3;
  localparam code_t CLS_INVALID = 3'd4;

endpackage

// ===== rtl/core/scclc_if.sv =====
// Valid/ready channel interfaces for sample input and classification output.
interface scclc_in_if;
  logic                valid;
  logic                ready;
  scclc_pkg::code_t    mode;
  scclc_pkg::mv_t      sample_mv;
  scclc_pkg::mv_t      reference_mv;

  modport source (output valid, mode, sample_mv, reference_mv, input ready);
  modport sink   (input valid, mode, sample_mv, reference_mv, output ready);
endinterface

interface scclc_out_if;
  logic                valid;
  logic                ready;
  scclc_pkg::code_t    level;
  scclc_pkg::code_t    power_class_out;

  modport source (output valid, level, power_class_out, input ready);
  modport sink   (input valid, level, power_class_out, output ready);
endinterface

// ===== rtl/core/smartcard_contact_level_checker.sv =====
// Smart-card contact level checker: classifies contact voltage samples.
//
// in_ch carries one millivolt sample per transaction with its contact mode and
// a reference voltage (read only in the high-z and state-A modes). out_ch
// returns exactly one transaction per input: the level code and the supply
// class as it stands after that sample. A vcc-mode sample updates the stored
// supply voltage and class, which all later samples are judged against.
//
// Path: a transaction accepted on in_ch is taken into the input register; its
// result moves into the result register once that register is free and is
// presented on out_ch from there.
// Throughput: one transaction per cycle unless out_ch stalls; the classification
// is a single pass of constant-multiplier compares between input and result registers.
//
// Reset (rst_n low, synchronous) empties both registers and returns the
// stored supply to 0 mV, class off. When the receiver stalls, the result
// holds in the output register and one further transaction waits in the
// input register; in_ch.ready falls only when both are full and out_ch is
// not taking its transaction.
module smartcard_contact_level_checker (
  input  logic            clk,
  input  logic            rst_n,
  scclc_in_if.sink        in_ch,
  scclc_out_if.source     out_ch
);

  localparam int unsigned PW = 20; // wide enough for 100 * 8191

  // input register
  logic              s1_valid_r;
  scclc_pkg::code_t  s1_mode_r;
  scclc_pkg::mv_t    s1_x_r;
  scclc_pkg::mv_t    s1_ref_r;

  // result register
  logic              s2_valid_r;
  scclc_pkg::code_t  s2_level_r;
  scclc_pkg::code_t  s2_class_r;

  // supply state
  scclc_pkg::code_t  class_r, class_nxt;
  scclc_pkg::mv_t    supply_r, supply_nxt;
  scclc_pkg::code_t  level_nxt;

  logic s2_free, s1_adv;

  assign s2_free      = !s2_valid_r || out_ch.ready;
  assign s1_adv       = s1_valid_r && s2_free;
  assign in_ch.ready  = !s1_valid_r || s2_free;

  assign out_ch.valid           = s2_valid_r;
  assign out_ch.level           = s2_level_r;
  assign out_ch.power_class_out = s2_class_r;

  // scaled operands
  logic [PW-1:0] x1, s1, r1, x10, x100, s2x, s7, s8, r7, r15;
  logic          powered, hi07;

  always_comb begin
    x1   = PW'(s1_x_r);
    s1   = PW'(supply_r);
    r1   = PW'(s1_ref_r);
    x10  = x1 * PW'(10);
    x100 = x1 * PW'(100);
    s2x  = s1 * PW'(2);
    s7   = s1 * PW'(7);
    s8   = s1 * PW'(8);
    r7   = r1 * PW'(7);
    r15  = r1 * PW'(15);
    powered = (class_r == scclc_pkg::CLS_A) || (class_r == scclc_pkg::CLS_B) ||
              (class_r == scclc_pkg::CLS_C);
    hi07 = (x10 >= s7) && (x1 <= s1);
  end

  function automatic scclc_pkg::code_t classify(scclc_pkg::mv_t v);
    scclc_pkg::code_t c;
    if (v >= 13'd4500 && v <= 13'd5500)      c = scclc_pkg::CLS_A;
    else if (v >= 13'd2700 && v <= 13'd3300) c = scclc_pkg::CLS_B;
    else if (v >= 13'd1620 && v <= 13'd1980) c = scclc_pkg::CLS_C;
    else if (v < 13'd400)                    c = scclc_pkg::CLS_OFF;
    else                                     c = scclc_pkg::CLS_INVALID;
    return c;
  endfunction

  always_comb begin
    class_nxt  = class_r;
    supply_nxt = supply_r;
    level_nxt  = scclc_pkg::LVL_ERR;
    unique case (s1_mode_r)
      scclc_pkg::MODE_VCC: begin
        class_nxt  = classify(s1_x_r);
        supply_nxt = s1_x_r;
      end
      scclc_pkg::MODE_RST: begin
        case (class_r) inside
          scclc_pkg::CLS_A: begin
            if ((x1 + PW'(700) >= s1) && (x1 <= s1)) level_nxt = scclc_pkg::LVL_HIGH;
            else if (x1 <= PW'(600))                 level_nxt = scclc_pkg::LVL_LOW;
          end
          scclc_pkg::CLS_B, scclc_pkg::CLS_C: begin
            if ((x10 >= s8) && (x1 <= s1)) level_nxt = scclc_pkg::LVL_HIGH;
            else if (x10 <= s2x)           level_nxt = scclc_pkg::LVL_LOW;
          end
          scclc_pkg::CLS_OFF: begin
            if (x1 <= PW'(400)) level_nxt = scclc_pkg::LVL_LOW;
          end
          default: level_nxt = scclc_pkg::LVL_ERR;
        endcase
      end
      scclc_pkg::MODE_IO: begin
        case (class_r)
          scclc_pkg::CLS_A: begin
            if ((x1 >= PW'(3800)) && (x1 <= s1)) level_nxt = scclc_pkg::LVL_HIGH;
            else if (x1 <= PW'(400))             level_nxt = scclc_pkg::LVL_LOW;
          end
          scclc_pkg::CLS_B: begin
            if (hi07)                 level_nxt = scclc_pkg::LVL_HIGH;
            else if (x1 <= PW'(400))  level_nxt = scclc_pkg::LVL_LOW;
          end
          scclc_pkg::CLS_C: begin
            if (hi07)                 level_nxt = scclc_pkg::LVL_HIGH;
            else if (x1 <= PW'(300))  level_nxt = scclc_pkg::LVL_LOW;
          end
          scclc_pkg::CLS_OFF: begin
            if (x1 <= PW'(400)) level_nxt = scclc_pkg::LVL_LOW;
          end
          default: level_nxt = scclc_pkg::LVL_ERR;
        endcase
      end
      scclc_pkg::MODE_CLK: begin
        case (class_r) inside
          scclc_pkg::CLS_A: begin
            if (hi07)                 level_nxt = scclc_pkg::LVL_HIGH;
            else if (x1 <= PW'(500))  level_nxt = scclc_pkg::LVL_LOW;
          end
          scclc_pkg::CLS_B, scclc_pkg::CLS_C: begin
            if (hi07)              level_nxt = scclc_pkg::LVL_HIGH;
            else if (x10 <= s2x)   level_nxt = scclc_pkg::LVL_LOW;
          end
          scclc_pkg::CLS_OFF: begin
            if (x1 <= PW'(400)) level_nxt = scclc_pkg::LVL_LOW;
          end
          default: level_nxt = scclc_pkg::LVL_ERR;
        endcase
      end
      scclc_pkg::MODE_VPP: begin
        if ((x1 >= PW'(4500)) && (x1 <= PW'(5500))) level_nxt = scclc_pkg::LVL_HIGH;
      end
      scclc_pkg::MODE_HIGHZ: begin
        // pull-up current 16..24 uA, solved for the sample
        if (powered && (x10 > r7) && (x1 < r1 + PW'(300)) &&
            (x10 >= PW'(7788)) && (x10 <= PW'(8052)))
          level_nxt = scclc_pkg::LVL_HIGHZ;
      end
      scclc_pkg::MODE_STATEA: begin
        // pull-up current 800..1200 uA
        if (powered && (x100 <= r15) &&
            (x10 >= PW'(33660)) && (x10 <= PW'(46860)))
          level_nxt = scclc_pkg::LVL_STATEA;
      end
      default: level_nxt = scclc_pkg::LVL_ERR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      class_r    <= scclc_pkg::CLS_OFF;
      supply_r   <= '0;
    end else begin
      if (in_ch.ready) s1_valid_r <= in_ch.valid;
      if (s2_free)     s2_valid_r <= s1_valid_r;
      if (s1_adv) begin
        class_r  <= class_nxt;
        supply_r <= supply_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_mode_r <= in_ch.mode;
      s1_x_r    <= in_ch.sample_mv;
      s1_ref_r  <= in_ch.reference_mv;
    end
    if (s1_adv) begin
      s2_level_r <= level_nxt;
      s2_class_r <= class_nxt;
    end
  end

endmodule

// ===== rtl/core/scclc_checker.sv =====
// Port-level assertions for the contact level checker, bound to the top level.
module scclc_checker (
  input logic             clk,
  input logic             rst_n,
  input logic             out_valid,
  input logic             out_ready,
  input scclc_pkg::code_t out_level,
  input scclc_pkg::code_t out_class
);

  // a stalled result transaction stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result transaction dropped while stalled");

  // nothing is offered straight after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered after reset");

  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_level <= scclc_pkg::LVL_STATEA) &&
                  (out_class <= scclc_pkg::CLS_INVALID))
    else $error("level or class code out of range");

  // high-z and state-A need a powered card
  a_powered: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_level == scclc_pkg::LVL_HIGHZ ||
                  out_level == scclc_pkg::LVL_STATEA)
      |-> (out_class == scclc_pkg::CLS_A || out_class == scclc_pkg::CLS_B ||
           out_class == scclc_pkg::CLS_C))
    else $error("high-z or state-A reported without supply");

endmodule

bind smartcard_contact_level_checker scclc_checker u_scclc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_level (out_ch.level),
  .out_class (out_ch.power_class_out)
);

// ===== sim/tb_top.sv =====
// Testbench for the smart-card contact level checker: directed and random samples.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam scclc_pkg::code_t MODE_UNUSED = 3'd7;
  localparam int unsigned RANDOM_ITEMS = 1850;

  typedef struct packed {
    scclc_pkg::code_t level;
    scclc_pkg::code_t power_class;
  } contact_result_t;

  logic clk;
  logic rst_n;

  scclc_in_if  in_ch ();
  scclc_out_if out_ch ();

  smartcard_contact_level_checker uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // shadow of the block's stored supply
  scclc_pkg::code_t class_q;
  int unsigned      supply_mv_q;

  contact_result_t expected_q[$];
  int unsigned     fail_count = 0;
  int unsigned     burst_left;

  int unsigned stall_cycle = 0;
  logic [1:0]  stall_style = 2'd0;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial begin
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic scclc_pkg::code_t supply_class_of(int unsigned v);
    if (v >= 4500 && v <= 5500) return scclc_pkg::CLS_A;
    if (v >= 2700 && v <= 3300) return scclc_pkg::CLS_B;
    if (v >= 1620 && v <= 1980) return scclc_pkg::CLS_C;
    if (v < 400) return scclc_pkg::CLS_OFF;
    return scclc_pkg::CLS_INVALID;
  endfunction

  // 0.7*s <= x <= s, compared as integer products
  function automatic bit in_07_window(int unsigned x, int unsigned s);
    return (10 * x >= 7 * s) && (x <= s);
  endfunction

  function automatic contact_result_t predict_contact(scclc_pkg::code_t mode,
                                                      scclc_pkg::mv_t x_in,
                                                      scclc_pkg::mv_t r_in);
    int unsigned     x;
    int unsigned     r;
    int unsigned     s;
    bit              powered;
    contact_result_t res;
    x = x_in;
    r = r_in;
    s = supply_mv_q;
    powered = (class_q == scclc_pkg::CLS_A) || (class_q == scclc_pkg::CLS_B) ||
              (class_q == scclc_pkg::CLS_C);
    res.level = scclc_pkg::LVL_ERR;
    case (mode)
      scclc_pkg::MODE_VCC: begin
        class_q = supply_class_of(x);
        supply_mv_q = x;
      end
      scclc_pkg::MODE_RST: begin
        case (class_q)
          scclc_pkg::CLS_A: begin
            if (x + 700 >= s && x <= s) res.level = scclc_pkg::LVL_HIGH;
            else if (x <= 600) res.level = scclc_pkg::LVL_LOW;
          end
          scclc_pkg::CLS_B, scclc_pkg::CLS_C: begin
            if (10 * x >= 8 * s && x <= s) res.level = scclc_pkg::LVL_HIGH;
            else if (10 * x <= 2 * s) res.level = scclc_pkg::LVL_LOW;
          end
          scclc_pkg::CLS_OFF: if (x <= 400) res.level = scclc_pkg::LVL_LOW;
          default: ;
        endcase
      end
      scclc_pkg::MODE_IO: begin
        case (class_q)
          scclc_pkg::CLS_A: begin
            if (x >= 3800 && x <= s) res.level = scclc_pkg::LVL_HIGH;
            else if (x <= 400) res.level = scclc_pkg::LVL_LOW;
          end
          scclc_pkg::CLS_B: begin
            if (in_07_window(x, s)) res.level = scclc_pkg::LVL_HIGH;
            else if (x <= 400) res.level = scclc_pkg::LVL_LOW;
          end
          scclc_pkg::CLS_C: begin
            if (in_07_window(x, s)) res.level = scclc_pkg::LVL_HIGH;
            else if (x <= 300) res.level = scclc_pkg::LVL_LOW;
          end
          scclc_pkg::CLS_OFF: if (x <= 400) res.level = scclc_pkg::LVL_LOW;
          default: ;
        endcase
      end
      scclc_pkg::MODE_CLK: begin
        case (class_q)
          scclc_pkg::CLS_A: begin
            if (in_07_window(x, s)) res.level = scclc_pkg::LVL_HIGH;
            else if (x <= 500) res.level = scclc_pkg::LVL_LOW;
          end
          scclc_pkg::CLS_B, scclc_pkg::CLS_C: begin
            if (in_07_window(x, s)) res.level = scclc_pkg::LVL_HIGH;
            else if (10 * x <= 2 * s) res.level = scclc_pkg::LVL_LOW;
          end
          scclc_pkg::CLS_OFF: if (x <= 400) res.level = scclc_pkg::LVL_LOW;
          default: ;
        endcase
      end
      scclc_pkg::MODE_VPP: if (x >= 4500 && x <= 5500) res.level = scclc_pkg::LVL_HIGH;
      scclc_pkg::MODE_HIGHZ: begin
        // pull-up of 16..24 uA solved for the contact voltage
        if (powered && 10 * x > 7 * r && x < r + 300 &&
            10 * x >= 7788 && 10 * x <= 8052)
          res.level = scclc_pkg::LVL_HIGHZ;
      end
      scclc_pkg::MODE_STATEA: begin
        if (powered && 100 * x <= 15 * r && 10 * x >= 33660 && 10 * x <= 46860)
          res.level = scclc_pkg::LVL_STATEA;
      end
      default: ;
    endcase
    res.power_class = class_q;
    return res;
  endfunction

  task automatic send_sample(input scclc_pkg::code_t mode, input int unsigned x,
                             input int unsigned r);
    int unsigned gap;
    in_ch.valid        <= 1'b1;
    in_ch.mode         <= mode;
    in_ch.sample_mv    <= scclc_pkg::mv_t'(x);
    in_ch.reference_mv <= scclc_pkg::mv_t'(r);
    do @(posedge clk); while (!in_ch.ready);
    expected_q.push_back(predict_contact(mode, scclc_pkg::mv_t'(x), scclc_pkg::mv_t'(r)));
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_ch.valid <= 1'b0;
      gap = $urandom_range(1, 6);
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(0, 30);
    end
  endtask

  // receiver: style is redrawn whenever stall_cycle[5:0] is zero, from always ready to long stalls
  always @(posedge clk) begin
    stall_cycle <= stall_cycle + 1;
    if (stall_cycle[5:0] == 6'd0) stall_style <= 2'($urandom_range(0, 3));
    case (stall_style)
      2'd0: out_ch.ready <= 1'b1;
      2'd1: out_ch.ready <= 1'($urandom_range(0, 1));
      2'd2: out_ch.ready <= (stall_cycle[1:0] == 2'd0);
      default: out_ch.ready <= (stall_cycle[4:3] != 2'b11);
    endcase
  end

  always @(posedge clk) begin : check_results
    contact_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected transaction, expected none, actual level %0d class %0d",
                 $time, out_ch.level, out_ch.power_class_out);
        fail_count++;
      end else begin
        want = expected_q.pop_front();
        if (out_ch.level !== want.level) begin
          $display("%0t: level mismatch, expected %0d actual %0d",
                   $time, want.level, out_ch.level);
          fail_count++;
        end
        if (out_ch.power_class_out !== want.power_class) begin
          $display("%0t: class mismatch, expected %0d actual %0d",
                   $time, want.power_class, out_ch.power_class_out);
          fail_count++;
        end
      end
    end
  end

  function automatic int unsigned pick_supply();
    int unsigned edges[14] = '{399, 400, 1619, 1620, 1980, 1981, 2699, 2700,
                               3300, 3301, 4499, 4500, 5500, 5501};
    case ($urandom_range(0, 9))
      0, 1:    return $urandom_range(4500, 5500);
      2, 3:    return $urandom_range(2700, 3300);
      4, 5:    return $urandom_range(1620, 1980);
      6:       return $urandom_range(0, 399);
      7:       return edges[$urandom_range(0, 13)];
      default: return $urandom_range(0, 8191);
    endcase
  endfunction

  // samples clustered on the window edges of the current supply
  function automatic int unsigned pick_level_sample(scclc_pkg::code_t mode);
    int unsigned s;
    int unsigned t;
    int unsigned fixed_edges[10] = '{300, 301, 400, 401, 500, 501, 600, 601, 3799, 3800};
    s = supply_mv_q;
    if (mode == scclc_pkg::MODE_HIGHZ && $urandom_range(0, 1)) return $urandom_range(770, 810);
    if (mode == scclc_pkg::MODE_STATEA && $urandom_range(0, 1))
      return $urandom_range(3360, 4690);
    case ($urandom_range(0, 9))
      0: return s + $urandom_range(0, 1);
      1: begin
        t = (7 * s + 9) / 10;
        return (t > 0) ? t - $urandom_range(0, 1) : t;
      end
      2: begin
        t = (8 * s + 9) / 10;
        return (t > 0) ? t - $urandom_range(0, 1) : t;
      end
      3: return (2 * s) / 10 + $urandom_range(0, 1);
      4: return (s >= 701) ? s - 700 - $urandom_range(0, 1) : 0;
      5: return fixed_edges[$urandom_range(0, 9)];
      6: return $urandom_range(4499, 5501);
      default: return $urandom_range(0, 8191);
    endcase
  endfunction

  function automatic int unsigned pick_reference(scclc_pkg::code_t mode, int unsigned x);
    if (mode == scclc_pkg::MODE_HIGHZ && $urandom_range(0, 2) != 0)
      return $urandom_range((x > 310) ? x - 310 : 0, (x * 10) / 7 + 10);
    return $urandom_range(0, 8191);
  endfunction

  task automatic test_unpowered;
    send_sample(scclc_pkg::MODE_RST, 400, 0);
    send_sample(scclc_pkg::MODE_IO, 401, 0);
    send_sample(scclc_pkg::MODE_HIGHZ, 790, 1000);
  endtask

  task automatic test_vpp_and_unused;
    send_sample(scclc_pkg::MODE_VPP, 4500, 0);
    send_sample(scclc_pkg::MODE_VPP, 5501, 8191);
    send_sample(MODE_UNUSED, 8191, 8191);
  endtask

  task automatic test_class_a;
    send_sample(scclc_pkg::MODE_VCC, 0, 0);
    send_sample(scclc_pkg::MODE_VCC, 5000, 0);
    send_sample(scclc_pkg::MODE_RST, 4300, 0);
    send_sample(scclc_pkg::MODE_IO, 3800, 0);
    send_sample(scclc_pkg::MODE_CLK, 501, 0);
    send_sample(scclc_pkg::MODE_HIGHZ, 790, 1000);
    // state A window can never meet 0.15*ref within 13 bits
    send_sample(scclc_pkg::MODE_STATEA, 3366, 8191);
  endtask

  task automatic test_class_b_c;
    send_sample(scclc_pkg::MODE_VCC, 3300, 0);
    send_sample(scclc_pkg::MODE_RST, 2640, 0);
    send_sample(scclc_pkg::MODE_CLK, 660, 0);
    send_sample(scclc_pkg::MODE_IO, 2310, 0);
    send_sample(scclc_pkg::MODE_VCC, 1620, 0);
    send_sample(scclc_pkg::MODE_IO, 300, 0);
    send_sample(scclc_pkg::MODE_IO, 301, 0);
    send_sample(scclc_pkg::MODE_VCC, 1980, 0);
  endtask

  task automatic test_invalid_class;
    send_sample(scclc_pkg::MODE_VCC, 8191, 0);
    send_sample(scclc_pkg::MODE_CLK, 0, 0);
    send_sample(scclc_pkg::MODE_VCC, 4499, 0);
    send_sample(scclc_pkg::MODE_RST, 0, 0);
  endtask

  task automatic test_random_traffic;
    int unsigned      sent;
    int unsigned      run_len;
    int unsigned      x;
    scclc_pkg::code_t m;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 9) == 0) begin
        send_sample(scclc_pkg::code_t'($urandom_range(0, 7)), $urandom_range(0, 8191),
                    $urandom_range(0, 8191));
        sent++;
      end else begin
        send_sample(scclc_pkg::MODE_VCC, pick_supply(), $urandom_range(0, 8191));
        run_len = $urandom_range(1, 12);
        repeat (run_len) begin
          m = ($urandom_range(0, 19) == 0) ? MODE_UNUSED
                                            : scclc_pkg::code_t'($urandom_range(1, 6));
          x = pick_level_sample(m);
          send_sample(m, x, pick_reference(m, x));
        end
        sent += run_len + 1;
      end
    end
  endtask

  initial begin
    class_q            = scclc_pkg::CLS_OFF;
    supply_mv_q        = 0;
    burst_left         = 8;
    rst_n              <= 1'b0;
    in_ch.valid        <= 1'b0;
    in_ch.mode         <= scclc_pkg::MODE_VCC;
    in_ch.sample_mv    <= '0;
    in_ch.reference_mv <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    test_unpowered();
    test_vpp_and_unused();
    test_class_a();
    test_class_b_c();
    test_invalid_class();
    test_random_traffic();

    in_ch.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/scclc_pkg.sv
rtl/core/scclc_if.sv
rtl/core/smartcard_contact_level_checker.sv
rtl/core/scclc_checker.sv
sim/tb_top.sv
